// File: rtl/core/ray_triangle_intersect_assert.svh
// Assertion macros for the RTL core, included by ray_triangle_intersect.sv.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rti_pkg.sv
`default_nettype none

package rti_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q_ONE     = 65536;

	typedef enum logic [2:0] {
		REG_TRI_ORIGIN   = 3'd0,
		REG_TRI_EDGE_U   = 3'd1,
		REG_TRI_EDGE_V   = 3'd2,
		REG_PLANE_NORMAL = 3'd3,
		REG_PLANE_OFFSET = 3'd4,
		REG_BARY_SCALE   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] ray_org_x;
		logic [31:0] ray_org_y;
		logic [31:0] ray_org_z;
		logic [31:0] ray_dir_x;
		logic [31:0] ray_dir_y;
		logic [31:0] ray_dir_z;
		logic [31:0] t_lower;
		logic [31:0] t_upper;
	} ray_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] t_hit;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [16:0] bary_alpha;
		logic [16:0] bary_beta;
	} ray_rsp_t;

	// per-request context carried down the pipe
	typedef struct packed {
		logic            miss;
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [31:0]      tlo;
		logic [31:0]      thi;
		logic [31:0]      t;
		logic [2:0][31:0] pos;
	} ctx_t;

	function automatic logic signed [20:0] lane_f(input logic [62:0] r, input logic [1:0] k);
		lane_f = $signed(r[21*k +: 21]);
	endfunction

	function automatic logic signed [41:0] sat42(input logic signed [63:0] x);
		logic signed [63:0] lim;
		lim = 64'sd1 <<< 40;
		if (x > lim)
			sat42 = 42'(lim);
		else if (x < -lim)
			sat42 = 42'(-lim);
		else
			sat42 = 42'(x);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] x);
		if (x > 50'sd2147483647)
			sat32 = 32'h7FFF_FFFF;
		else if (x < -50'sd2147483648)
			sat32 = 32'h8000_0000;
		else
			sat32 = x[31:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ray_triangle_intersect.sv
`default_nettype none
// channel   valid      stall      payload
// request   req_valid  req_stall  req (ray_req_t)
// result    rsp_valid  rsp_stall  rsp (ray_rsp_t)
// config    cfg_we     -          cfg_idx, cfg_data
//
// One request per cycle while req_stall is low; results come out in request order.
// The quotient for t is built one bit per stage, in 32 stages.
// arst_n clears all valid bits and the configuration registers.
// A held result freezes the whole pipe; req_stall follows it directly.

module ray_triangle_intersect (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire rti_pkg::ray_req_t  req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rti_pkg::ray_rsp_t       rsp,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [62:0]        cfg_data
);
	import rti_pkg::*;

	`include "ray_triangle_intersect_assert.svh"

	localparam int DIV_STEPS = 32;

	logic [62:0] tri_origin_q, tri_edge_u_q, tri_edge_v_q, plane_normal_q, bary_scale_q;
	logic [31:0] plane_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_origin_q   <= '0;
			tri_edge_u_q   <= '0;
			tri_edge_v_q   <= '0;
			plane_normal_q <= '0;
			plane_offset_q <= '0;
			bary_scale_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TRI_ORIGIN:   tri_origin_q   <= cfg_data;
				REG_TRI_EDGE_U:   tri_edge_u_q   <= cfg_data;
				REG_TRI_EDGE_V:   tri_edge_v_q   <= cfg_data;
				REG_PLANE_NORMAL: plane_normal_q <= cfg_data;
				REG_PLANE_OFFSET: plane_offset_q <= cfg_data[31:0];
				REG_BARY_SCALE:   bary_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [20:0] n_l [3];
	logic signed [20:0] u_l [3];
	logic signed [20:0] v_l [3];
	logic signed [20:0] w_l [3];
	logic signed [20:0] o_l [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_l[k] = lane_f(plane_normal_q, 2'(k));
			u_l[k] = lane_f(tri_edge_u_q, 2'(k));
			v_l[k] = lane_f(tri_edge_v_q, 2'(k));
			w_l[k] = lane_f(bary_scale_q, 2'(k));
			o_l[k] = lane_f(tri_origin_q, 2'(k));
		end
	end

	logic adv;
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// s1: dot-product terms
	logic               v_s1;
	ctx_t               ctx_s1;
	logic signed [52:0] pd_s1 [3];
	logic signed [52:0] po_s1 [3];
	ctx_t               ctx_in;

	always_comb begin
		ctx_in      = '0;
		ctx_in.org  = {req.ray_org_z, req.ray_org_y, req.ray_org_x};
		ctx_in.dir  = {req.ray_dir_z, req.ray_dir_y, req.ray_dir_x};
		ctx_in.tlo  = req.t_lower;
		ctx_in.thi  = req.t_upper;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ctx_in;
			for (int k = 0; k < 3; k++) begin
				pd_s1[k] <= n_l[k] * $signed(ctx_in.dir[k]);
				po_s1[k] <= n_l[k] * $signed(ctx_in.org[k]);
			end
		end
	end

	// s2: denominator and numerator
	logic               v_s2;
	ctx_t               ctx_s2;
	logic signed [55:0] den_s2, num_s2;
	logic signed [55:0] den_c, num_c;
	ctx_t               ctx2_c;

	always_comb begin
		den_c = 56'(pd_s1[0]) + 56'(pd_s1[1]) + 56'(pd_s1[2]);
		num_c = (56'($signed(plane_offset_q)) <<< 10)
			- (56'(po_s1[0]) + 56'(po_s1[1]) + 56'(po_s1[2]));
		ctx2_c      = ctx_s1;
		ctx2_c.miss = (den_c == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= ctx2_c;
			den_s2 <= den_c;
			num_s2 <= num_c;
		end
	end

	// s3: magnitudes and quotient sign
	logic        v_s3;
	ctx_t        ctx_s3;
	logic [55:0] nm_s3, dm_s3;
	logic        neg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx_s2;
			nm_s3  <= num_s2[55] ? 56'(-num_s2) : 56'(num_s2);
			dm_s3  <= den_s2[55] ? 56'(-den_s2) : 56'(den_s2);
			neg_s3 <= num_s2[55] != den_s2[55];
		end
	end

	// s4 feeds the divider; a quotient above 32 bits is a miss
	logic [55:0] dv_rem_s [DIV_STEPS+1];
	logic [31:0] dv_lo_s  [DIV_STEPS+1];
	logic [31:0] dv_q_s   [DIV_STEPS+1];
	logic [55:0] dv_dm_s  [DIV_STEPS+1];
	logic        dv_neg_s [DIV_STEPS+1];
	ctx_t        dv_ctx_s [DIV_STEPS+1];
	logic        dv_v_s   [DIV_STEPS+1];
	logic [55:0] rem0_c;
	ctx_t        dv_ctx0_c;

	assign rem0_c = nm_s3 >> FRAC_BITS;

	always_comb begin
		dv_ctx0_c      = ctx_s3;
		dv_ctx0_c.miss = ctx_s3.miss || (rem0_c >= dm_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctx_s[0] <= dv_ctx0_c;
			dv_rem_s[0] <= rem0_c;
			dv_lo_s[0]  <= 32'(nm_s3[FRAC_BITS-1:0]) << (32 - FRAC_BITS);
			dv_q_s[0]   <= '0;
			dv_dm_s[0]  <= dm_s3;
			dv_neg_s[0] <= neg_s3;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [56:0] r2;
		logic        ge;
		logic [56:0] diff;

		assign r2   = {dv_rem_s[j], dv_lo_s[j][31]};
		assign ge   = r2 >= {1'b0, dv_dm_s[j]};
		assign diff = r2 - {1'b0, dv_dm_s[j]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j+1] <= ge ? diff[55:0] : r2[55:0];
				dv_lo_s[j+1]  <= dv_lo_s[j] << 1;
				dv_q_s[j+1]   <= {dv_q_s[j][30:0], ge};
				dv_dm_s[j+1]  <= dv_dm_s[j];
				dv_neg_s[j+1] <= dv_neg_s[j];
				dv_ctx_s[j+1] <= dv_ctx_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (adv)
				dv_v_s[j+1] <= dv_v_s[j];
		end
	end

	// s5: signed t and window test
	logic        v_s5;
	ctx_t        ctx_s5;
	logic [31:0] qf, t_c;
	logic        bad_c;
	ctx_t        ctx5_c;

	always_comb begin
		qf    = dv_q_s[DIV_STEPS];
		t_c   = dv_neg_s[DIV_STEPS] ? (~qf + 32'd1) : qf;
		bad_c = dv_neg_s[DIV_STEPS] ? (qf > 32'h8000_0000) : qf[31];
		ctx5_c      = dv_ctx_s[DIV_STEPS];
		ctx5_c.t    = t_c;
		ctx5_c.miss = dv_ctx_s[DIV_STEPS].miss || bad_c
			|| ($signed(t_c) < $signed(dv_ctx_s[DIV_STEPS].tlo))
			|| ($signed(t_c) > $signed(dv_ctx_s[DIV_STEPS].thi));
	end

	always_ff @(posedge clk) begin
		if (adv)
			ctx_s5 <= ctx5_c;
	end

	// s6: dir * t
	logic               v_s6;
	ctx_t               ctx_s6;
	logic signed [63:0] pt_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6 <= ctx_s5;
			for (int k = 0; k < 3; k++)
				pt_s6[k] <= $signed(ctx_s5.dir[k]) * $signed(ctx_s5.t);
		end
	end

	// s7: hit position
	logic               v_s7;
	ctx_t               ctx_s7;
	logic signed [49:0] pos_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s7 <= ctx_s6;
			for (int k = 0; k < 3; k++)
				pos_s7[k] <= 50'($signed(ctx_s6.org[k]))
					+ 50'($signed(pt_s6[k][63:FRAC_BITS]));
		end
	end

	// s8: position relative to first vertex, saturated output position
	logic               v_s8;
	ctx_t               ctx_s8;
	logic signed [41:0] p_s8 [3];
	logic signed [49:0] p_c  [3];
	ctx_t               ctx8_c;

	always_comb begin
		ctx8_c = ctx_s7;
		for (int k = 0; k < 3; k++) begin
			p_c[k]        = pos_s7[k] - (50'(o_l[k]) <<< (FRAC_BITS - 10));
			ctx8_c.pos[k] = sat32(pos_s7[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s8 <= ctx8_c;
			for (int k = 0; k < 3; k++)
				p_s8[k] <= sat42(64'(p_c[k]));
		end
	end

	// s9: cross-product terms
	logic               v_s9;
	ctx_t               ctx_s9;
	logic signed [62:0] a_pos_s9 [3];
	logic signed [62:0] a_neg_s9 [3];
	logic signed [62:0] b_pos_s9 [3];
	logic signed [62:0] b_neg_s9 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s9      <= ctx_s8;
			a_pos_s9[0] <= p_s8[1] * v_l[2];
			a_neg_s9[0] <= p_s8[2] * v_l[1];
			a_pos_s9[1] <= p_s8[2] * v_l[0];
			a_neg_s9[1] <= p_s8[0] * v_l[2];
			a_pos_s9[2] <= p_s8[0] * v_l[1];
			a_neg_s9[2] <= p_s8[1] * v_l[0];
			b_pos_s9[0] <= u_l[1] * p_s8[2];
			b_neg_s9[0] <= u_l[2] * p_s8[1];
			b_pos_s9[1] <= u_l[2] * p_s8[0];
			b_neg_s9[1] <= u_l[0] * p_s8[2];
			b_pos_s9[2] <= u_l[0] * p_s8[1];
			b_neg_s9[2] <= u_l[1] * p_s8[0];
		end
	end

	// s10: cross products, floored and saturated
	logic               v_s10;
	ctx_t               ctx_s10;
	logic signed [41:0] a_s10 [3];
	logic signed [41:0] b_s10 [3];
	logic signed [63:0] ad_c [3];
	logic signed [63:0] bd_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ad_c[k] = (64'(a_pos_s9[k]) - 64'(a_neg_s9[k])) >>> 10;
			bd_c[k] = (64'(b_pos_s9[k]) - 64'(b_neg_s9[k])) >>> 10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s10 <= ctx_s9;
			for (int k = 0; k < 3; k++) begin
				a_s10[k] <= sat42(ad_c[k]);
				b_s10[k] <= sat42(bd_c[k]);
			end
		end
	end

	// s11: scale terms
	logic               v_s11;
	ctx_t               ctx_s11;
	logic signed [62:0] wa_s11 [3];
	logic signed [62:0] wb_s11 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s11 <= ctx_s10;
			for (int k = 0; k < 3; k++) begin
				wa_s11[k] <= w_l[k] * a_s10[k];
				wb_s11[k] <= w_l[k] * b_s10[k];
			end
		end
	end

	// s12: alpha and beta
	logic               v_s12;
	ctx_t               ctx_s12;
	logic signed [53:0] alpha_s12, beta_s12;
	logic signed [63:0] sa_c, sb_c;

	always_comb begin
		sa_c = (64'(wa_s11[0]) + 64'(wa_s11[1]) + 64'(wa_s11[2])) >>> (FRAC_BITS - 6);
		sb_c = (64'(wb_s11[0]) + 64'(wb_s11[1]) + 64'(wb_s11[2])) >>> (FRAC_BITS - 6);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s12   <= ctx_s11;
			alpha_s12 <= 54'(sa_c);
			beta_s12  <= 54'(sb_c);
		end
	end

	// result register
	logic               ok_c;
	logic signed [54:0] ab_c;
	ray_rsp_t           rsp_c;
	logic               rsp_valid_q;
	ray_rsp_t           rsp_q;

	always_comb begin
		ab_c  = 55'(alpha_s12) + 55'(beta_s12);
		ok_c  = !ctx_s12.miss
			&& (alpha_s12 >= 54'sd0) && (alpha_s12 <= 54'(Q_ONE))
			&& (beta_s12 >= 54'sd0) && (beta_s12 <= 54'(Q_ONE))
			&& (ab_c <= 55'(Q_ONE));
		rsp_c = '0;
		if (ok_c) begin
			rsp_c.hit        = 1'b1;
			rsp_c.t_hit      = ctx_s12.t;
			rsp_c.pos_x      = ctx_s12.pos[0];
			rsp_c.pos_y      = ctx_s12.pos[1];
			rsp_c.pos_z      = ctx_s12.pos[2];
			rsp_c.bary_alpha = alpha_s12[16:0];
			rsp_c.bary_beta  = beta_s12[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			rsp_q <= rsp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			dv_v_s[0]   <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			dv_v_s[0]   <= v_s3;
			v_s5        <= dv_v_s[DIV_STEPS];
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s11       <= v_s10;
			v_s12       <= v_s11;
			rsp_valid_q <= v_s12;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RTI_ASSERT_NOW(a_div_rem_bound, dv_v_s[DIV_STEPS] && !dv_ctx_s[DIV_STEPS].miss,
		dv_rem_s[DIV_STEPS] < dv_dm_s[DIV_STEPS], "divider remainder not below divisor")
	`RTI_ASSERT_NOW(a_miss_zero, rsp_valid_q && !rsp_q.hit,
		rsp_q.t_hit == '0 && rsp_q.pos_x == '0 && rsp_q.pos_y == '0
		&& rsp_q.pos_z == '0 && rsp_q.bary_alpha == '0 && rsp_q.bary_beta == '0,
		"miss result carries nonzero fields")
	`RTI_ASSERT_NOW(a_bary_range, rsp_valid_q && rsp_q.hit,
		18'(rsp_q.bary_alpha) + 18'(rsp_q.bary_beta) <= 18'(Q_ONE),
		"barycentric weights exceed one")
	`RTI_ASSERT_NEXT(a_hold_pipe, rsp_valid_q && rsp_stall,
		rsp_valid_q && $stable(v_s12) && $stable(dv_v_s[0]),
		"pipeline moved while result held")

endmodule

`default_nettype wire

// File: tb/sv/rti_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module rti_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_stall,
	input  wire rti_pkg::ray_req_t req,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_stall,
	input  wire rti_pkg::ray_rsp_t rsp,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_idx,
	input  wire logic [62:0]       cfg_data,
	output int                     errors,
	output int                     pending,
	output int                     hits_seen
);
	import rti_pkg::*;

	localparam longint DEN_MIN = ((64'sd1 << (FRAC_BITS + 10)) + 99999999) / 100000000;
	localparam longint P_LIM   = 64'sd1 << 40;

	logic [62:0] tri_org, edge_u, edge_v, nrm, bscale;
	logic [31:0] poff;
	ray_rsp_t    expected_q[$];

	function automatic longint lane_of(input logic [62:0] r, input int k);
		lane_of = longint'($signed(r[21*k +: 21]));
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		clip = x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic ray_rsp_t trace_ray(input ray_req_t r);
		longint org[3], dir[3], n[3], u[3], v[3], w[3], p[3], a[3], b[3], pos[3];
		longint den, num, t, tlo, thi, al, be, oq;
		logic [63:0] nm, dm, q, rm;
		logic neg;
		ray_rsp_t o;
		o = '0;
		org[0] = longint'($signed(r.ray_org_x));
		org[1] = longint'($signed(r.ray_org_y));
		org[2] = longint'($signed(r.ray_org_z));
		dir[0] = longint'($signed(r.ray_dir_x));
		dir[1] = longint'($signed(r.ray_dir_y));
		dir[2] = longint'($signed(r.ray_dir_z));
		tlo = longint'($signed(r.t_lower));
		thi = longint'($signed(r.t_upper));
		for (int k = 0; k < 3; k++) begin
			n[k] = lane_of(nrm, k);
			u[k] = lane_of(edge_u, k);
			v[k] = lane_of(edge_v, k);
			w[k] = lane_of(bscale, k);
		end
		den = n[0] * dir[0] + n[1] * dir[1] + n[2] * dir[2];
		if (den > -DEN_MIN && den < DEN_MIN)
			return o;
		num = longint'($signed(poff)) * 1024 - (n[0] * org[0] + n[1] * org[1] + n[2] * org[2]);
		neg = (num < 0) != (den < 0);
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		q = nm / dm;
		rm = nm % dm;
		if (q > 64'hFFFF_FFFF)
			return o;
		for (int i = 0; i < FRAC_BITS; i++) begin
			q = q << 1;
			rm = rm << 1;
			if (rm >= dm) begin
				rm = rm - dm;
				q = q + 1;
			end
		end
		if (neg) begin
			if (q > 64'h8000_0000)
				return o;
			t = -longint'(q);
		end else begin
			if (q > 64'h7FFF_FFFF)
				return o;
			t = longint'(q);
		end
		if (t < tlo || t > thi)
			return o;
		for (int k = 0; k < 3; k++) begin
			pos[k] = org[k] + ((dir[k] * t) >>> FRAC_BITS);
			oq = FRAC_BITS >= 10 ? lane_of(tri_org, k) <<< (FRAC_BITS - 10)
				: lane_of(tri_org, k) >>> (10 - FRAC_BITS);
			p[k] = clip(pos[k] - oq, -P_LIM, P_LIM);
		end
		a[0] = p[1] * v[2] - p[2] * v[1];
		a[1] = p[2] * v[0] - p[0] * v[2];
		a[2] = p[0] * v[1] - p[1] * v[0];
		b[0] = u[1] * p[2] - u[2] * p[1];
		b[1] = u[2] * p[0] - u[0] * p[2];
		b[2] = u[0] * p[1] - u[1] * p[0];
		for (int k = 0; k < 3; k++) begin
			a[k] = clip(a[k] >>> 10, -P_LIM, P_LIM);
			b[k] = clip(b[k] >>> 10, -P_LIM, P_LIM);
		end
		al = (w[0] * a[0] + w[1] * a[1] + w[2] * a[2]) >>> (FRAC_BITS - 6);
		be = (w[0] * b[0] + w[1] * b[1] + w[2] * b[2]) >>> (FRAC_BITS - 6);
		if (al < 0 || al > Q_ONE || be < 0 || be > Q_ONE || al + be > Q_ONE)
			return o;
		o.hit = 1'b1;
		o.t_hit = t[31:0];
		o.pos_x = 32'(clip(pos[0], -64'sd2147483648, 64'sd2147483647));
		o.pos_y = 32'(clip(pos[1], -64'sd2147483648, 64'sd2147483647));
		o.pos_z = 32'(clip(pos[2], -64'sd2147483648, 64'sd2147483647));
		o.bary_alpha = al[16:0];
		o.bary_beta = be[16:0];
		return o;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ray_rsp_t e;
		if (!arst_n) begin
			tri_org <= '0;
			edge_u <= '0;
			edge_v <= '0;
			nrm <= '0;
			poff <= '0;
			bscale <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					REG_TRI_ORIGIN:   tri_org <= cfg_data;
					REG_TRI_EDGE_U:   edge_u <= cfg_data;
					REG_TRI_EDGE_V:   edge_v <= cfg_data;
					REG_PLANE_NORMAL: nrm <= cfg_data;
					REG_PLANE_OFFSET: poff <= cfg_data[31:0];
					REG_BARY_SCALE:   bscale <= cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				expected_q.push_back(trace_ray(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report("result with no request outstanding", rsp.t_hit, 0);
				end else begin
					e = expected_q.pop_front();
					if (e.hit) hits_seen++;
					if (rsp.hit !== e.hit) report("hit", rsp.hit, e.hit);
					if (rsp.t_hit !== e.t_hit) report("t_hit", rsp.t_hit, e.t_hit);
					if (rsp.pos_x !== e.pos_x) report("pos_x", rsp.pos_x, e.pos_x);
					if (rsp.pos_y !== e.pos_y) report("pos_y", rsp.pos_y, e.pos_y);
					if (rsp.pos_z !== e.pos_z) report("pos_z", rsp.pos_z, e.pos_z);
					if (rsp.bary_alpha !== e.bary_alpha)
						report("bary_alpha", rsp.bary_alpha, e.bary_alpha);
					if (rsp.bary_beta !== e.bary_beta)
						report("bary_beta", rsp.bary_beta, e.bary_beta);
				end
			end
		end
	end

	initial begin
		errors = 0;
		hits_seen = 0;
	end
endmodule

`default_nettype wire

// File: tb/sv/tb_ray_triangle_intersect.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_ray_triangle_intersect;
	import rti_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	ray_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	ray_rsp_t    rsp;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = REG_TRI_ORIGIN;
	logic [62:0] cfg_data = '0;
	int          errors, pending, hits_seen, sent, stall_left, quiet_cnt;
	bit          quiet = 1'b0;

	// triangle in the z plane: origin lanes, edge lengths as powers of two
	longint      ox, oy, oz, ea, eb;

	always #10 clk = ~clk;

	ray_triangle_intersect dut (.*);

	rti_checker chk (.*);

	always @(posedge clk) begin
		if (quiet || stall_left == 0) begin
			rsp_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 19);
		end else begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt > 3000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [62:0] lanes(input longint x, input longint y, input longint z);
		lanes = {z[20:0], y[20:0], x[20:0]};
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [62:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [62:0] o, input logic [62:0] u, input logic [62:0] v,
			input logic [62:0] n, input logic [31:0] off, input logic [62:0] w);
		write_reg(REG_TRI_ORIGIN, o);
		write_reg(REG_TRI_EDGE_U, u);
		write_reg(REG_TRI_EDGE_V, v);
		write_reg(REG_PLANE_NORMAL, n);
		write_reg(REG_PLANE_OFFSET, off);
		write_reg(REG_BARY_SCALE, w);
	endtask

	task automatic tri_setup();
		ox = longint'($urandom_range(0, 8192)) - 4096;
		oy = longint'($urandom_range(0, 8192)) - 4096;
		oz = longint'($urandom_range(0, 8192)) - 4096;
		ea = 1 << $urandom_range(0, 3);
		eb = 1 << $urandom_range(0, 3);
		write_all(lanes(ox, oy, oz), lanes(ea * 1024, 0, 0), lanes(0, eb * 1024, 0),
			lanes(0, 0, 1024), 32'(oz * 64), lanes(0, 0, 1024 / (ea * eb)));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send(input ray_req_t r);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		forever begin
			@(negedge clk);
			if (!req_stall)
				break;
		end
		@(posedge clk);
		sent++;
	endtask

	function automatic ray_req_t noise_ray();
		ray_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return r;
	endfunction

	// ray aimed at a point near the triangle, coming down the z axis
	function automatic ray_req_t aimed_ray();
		ray_req_t r;
		longint tx, ty, h, dz;
		tx = ox * 64 + longint'($urandom_range(0, 32'(ea * 70000))) - 2000;
		ty = oy * 64 + longint'($urandom_range(0, 32'(eb * 70000))) - 2000;
		h = longint'($urandom_range(1, 20 * 65536));
		dz = longint'($urandom_range(16384, 131072));
		r.ray_org_x = 32'(tx);
		r.ray_org_y = 32'(ty);
		r.ray_org_z = 32'(oz * 64 + h);
		r.ray_dir_x = 32'(longint'($urandom_range(0, 4096)) - 2048);
		r.ray_dir_y = 32'(longint'($urandom_range(0, 4096)) - 2048);
		r.ray_dir_z = 32'(-dz);
		if ($urandom_range(0, 3) == 0) begin
			r.t_lower = $urandom_range(0, 20 * 65536);
			r.t_upper = $urandom_range(0, 40 * 65536);
		end else begin
			r.t_lower = 32'h0;
			r.t_upper = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	initial begin
		ray_req_t r;
		sent = 0;
		stall_left = 0;
		quiet_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: every ray is parallel to a zero normal
		repeat (10) send(noise_ray());
		drain();

		tri_setup();
		send(aimed_ray());
		r = aimed_ray();
		r.ray_dir_z = 32'h0;
		send(r);
		r = aimed_ray();
		r.t_lower = 32'h7FFF_FFFF;
		r.t_upper = 32'h8000_0000;
		send(r);
		r = aimed_ray();
		r.ray_dir_x = 32'h0;
		r.ray_dir_y = 32'h0;
		r.ray_dir_z = 32'hFFFF_FFFF;
		r.ray_org_z = 32'h7FFF_FFFF;
		send(r);
		r = aimed_ray();
		r.ray_dir_z = 32'h8000_0000;
		r.t_lower = 32'h8000_0000;
		send(r);
		r = '1;
		send(r);
		r = '0;
		send(r);
		r = {8{32'h8000_0000}};
		send(r);
		r = {8{32'h7FFF_FFFF}};
		send(r);
		repeat (10) send(aimed_ray());
		drain();

		// extreme register values, then random ones
		write_all('1, '1, '1, '1, 32'h7FFF_FFFF, '1);
		repeat (40) send(noise_ray());
		drain();
		write_all(lanes(-1048576, -1048576, -1048576), lanes(-1048576, -1048576, -1048576),
			lanes(-1048576, -1048576, -1048576), lanes(1048575, -1048576, 1048575),
			32'h8000_0000, lanes(1048575, 1048575, 1048575));
		repeat (40) send(noise_ray());
		drain();
		write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, $urandom, {$urandom, $urandom});
		repeat (40) send(noise_ray());
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			tri_setup();
			if (ph == 7)
				quiet = 1'b1;
			repeat (120)
				send($urandom_range(0, 4) == 0 ? noise_ray() : aimed_ray());
			drain();
		end

		$display("%0d rays sent through reset, extreme and random register settings", sent);
		$display("%0d of them hit the triangle", hits_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

`default_nettype wire
